// ===== sv/vkis_pkg.sv =====
// Package for the varying-kernel image subtraction block.
// Holds the sequencer state type, pipeline stage flags and fixed field widths.
// No dependencies.
`default_nettype none

package vkis_pkg;

   // fixed field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned POS_W   = 8;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned CSR_W   = 9;
   localparam int unsigned CSRI_W  = 2;
   localparam int unsigned HW_W    = 3;    // effective half width, up to 7
   localparam int unsigned DEG_W   = 2;    // effective degree, up to 3
   localparam int unsigned SIDE_W  = 13;   // effective side, up to 4096
   localparam int unsigned CRD_W   = 14;   // signed neighbour coordinate
   localparam int unsigned KC_W    = 4;    // kernel column or row counter
   localparam int unsigned TRM_W   = 4;    // term count, up to 10
   localparam int unsigned PROD_W  = 65;   // coefficient times pixel difference
   localparam int unsigned RND_W   = 42;   // rounded value clamped to +-2^40
   localparam int unsigned REF_DEPTH = 65536;

   localparam logic [OP_W-1:0] OP_WRITE_PIXEL = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_COEF  = 2'd1;
   localparam logic [OP_W-1:0] OP_EVALUATE    = 2'd2;

   localparam logic [CSRI_W-1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [CSRI_W-1:0] CSR_POLY_DEGREE = 2'd1;
   localparam logic [CSRI_W-1:0] CSR_IMAGE_SIDE  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CENTER,
      ST_CWAIT,
      ST_TAPS,
      ST_DRAIN,
      ST_SCALE,
      ST_ADDT,
      ST_ROUND,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic valid;
      logic capture;   // centre pixel fetch, not a tap
      logic center;
   } s1_type;

   typedef struct packed {
      logic valid;
      logic capture;
      logic center;
      logic inr;       // pixel lies inside the image
   } s2_type;

   // number of polynomial terms for a degree
   function automatic logic [TRM_W-1:0] terms_of(input logic [DEG_W-1:0] d);
      logic [TRM_W-1:0] t;
      case (d)
         2'd0:    t = 4'd1;
         2'd1:    t = 4'd3;
         2'd2:    t = 4'd6;
         default: t = 4'd10;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/vkis_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vkis_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/varying_kernel_image_subtract.sv =====
// Varying-kernel image subtraction: top level with sequencer and MAC pipeline.
// Depends on vkis_pkg and vkis_ram.
`default_nettype none

// Holds a reference image (65536 words, Q24.8) and a kernel coefficient table
// (Q8.24) in two synchronous RAMs, both loaded by write words on the request
// channel; reading a location never written gives an undefined result. An
// evaluate word fetches the centre pixel, then for each polynomial term
// streams every kernel tap through one read-multiply-accumulate pipeline (one
// tap a cycle, both RAMs read together), scales the term sum by x and y one
// factor a cycle, and adds it to a wide exact accumulator. Rounding and
// saturation to Q24.8 close the word. Each scale step applies one factor of x
// or y; the term weights hold none in all at degree 0, two at degree 1 and
// eight at degree 2. The kernel side is 2*half_width+1 and a degree d has
// (d+1)(d+2)/2 terms. All taps pass through the single multiplier. A new word
// is taken once the previous one has left the sequencer; the response
// register lets it wait for rsp_ready.
module varying_kernel_image_subtract #(
   parameter int unsigned IMAGE_SIDE     = 256,
   parameter int unsigned MAX_HALF_WIDTH = 3,
   parameter int unsigned MAX_DEGREE     = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [vkis_pkg::OP_W-1:0]     req_opcode,
   input  wire logic        [vkis_pkg::ADDR_W-1:0]   req_address,
   input  wire logic        [vkis_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic        [vkis_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic signed [vkis_pkg::DATA_W-1:0]   req_pixel_value,
   input  wire logic signed [vkis_pkg::DATA_W-1:0]   req_coef_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [vkis_pkg::DATA_W-1:0]   rsp_conv_value,
   output logic signed      [vkis_pkg::DATA_W-1:0]   rsp_difference,
   output logic                                      rsp_saturated,
   input  wire logic                                 csr_we,
   input  wire logic        [vkis_pkg::CSRI_W-1:0]   csr_index,
   input  wire logic        [vkis_pkg::CSR_W-1:0]    csr_wdata
);

   // derived sizes
   localparam int unsigned KSIDE      = 2 * MAX_HALF_WIDTH + 1;
   localparam int unsigned TERMS_MAX  = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
   localparam int unsigned COEF_DEPTH = KSIDE * KSIDE * TERMS_MAX;
   localparam int unsigned CIW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int unsigned TAW        = vkis_pkg::PROD_W + $clog2(KSIDE * KSIDE) + 1
                                        + vkis_pkg::POS_W * MAX_DEGREE;
   localparam int unsigned ACCW       = TAW + $clog2(TERMS_MAX) + 1;
   localparam int unsigned RW         = ACCW - 24;
   localparam int unsigned RAW        = vkis_pkg::SIDE_W + 2 * (vkis_pkg::CRD_W - 2);
   localparam logic signed [RW-1:0] CLAMP_HI = RW'(64'sd1 <<< 40);
   localparam logic signed [RW-1:0] CLAMP_LO = -CLAMP_HI;
   localparam logic signed [ACCW-1:0] HALF_LSB = ACCW'(64'sd1 <<< 23);

   // configuration registers
   logic [1:0]                    hw_ff;
   logic [1:0]                    deg_ff;
   logic [vkis_pkg::CSR_W-1:0]    side_ff;

   logic [vkis_pkg::HW_W-1:0]     hw_eff;
   logic [vkis_pkg::DEG_W-1:0]    deg_eff;
   logic [vkis_pkg::SIDE_W-1:0]   side_eff;
   logic [vkis_pkg::TRM_W-1:0]    terms_eff;
   logic [vkis_pkg::KC_W-1:0]     k_last;

   always_comb begin
      hw_eff  = (vkis_pkg::HW_W'(hw_ff) > vkis_pkg::HW_W'(MAX_HALF_WIDTH))
                ? vkis_pkg::HW_W'(MAX_HALF_WIDTH) : vkis_pkg::HW_W'(hw_ff);
      deg_eff = (vkis_pkg::DEG_W'(deg_ff) > vkis_pkg::DEG_W'(MAX_DEGREE))
                ? vkis_pkg::DEG_W'(MAX_DEGREE) : vkis_pkg::DEG_W'(deg_ff);
      side_eff = (vkis_pkg::SIDE_W'(side_ff) > vkis_pkg::SIDE_W'(IMAGE_SIDE))
                 ? vkis_pkg::SIDE_W'(IMAGE_SIDE) : vkis_pkg::SIDE_W'(side_ff);
      terms_eff = vkis_pkg::terms_of(deg_eff);
      k_last    = vkis_pkg::KC_W'({hw_eff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff   <= 2'd1;
         deg_ff  <= 2'd0;
         side_ff <= vkis_pkg::CSR_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            vkis_pkg::CSR_HALF_WIDTH:  hw_ff   <= csr_wdata[1:0];
            vkis_pkg::CSR_POLY_DEGREE: deg_ff  <= csr_wdata[1:0];
            vkis_pkg::CSR_IMAGE_SIDE:  side_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state and working registers
   vkis_pkg::state_type state_ff, state_in;

   logic [vkis_pkg::POS_W-1:0]      x_ff, y_ff;
   logic signed [vkis_pkg::DATA_W-1:0] sci_ff;
   logic [vkis_pkg::KC_W-1:0]       kx_ff, ky_ff;
   logic [CIW-1:0]                  cidx_ff;
   logic [CIW-1:0]                  tidx_ff;     // current term index
   logic [vkis_pkg::DEG_W-1:0]      m_ff, l_ff;
   logic [vkis_pkg::HW_W-1:0]       sc_ff;       // scale step counter
   logic signed [TAW-1:0]           term_acc_ff;
   logic signed [ACCW-1:0]          tot_ff;
   logic signed [RW-1:0]            rnd_ff;
   logic signed [vkis_pkg::DATA_W:0] rc_ff;

   // pipeline
   vkis_pkg::s1_type                s1_ff;
   vkis_pkg::s2_type                s2_ff;
   logic signed [vkis_pkg::CRD_W-1:0] s1_nx_ff, s1_ny_ff;
   logic [CIW-1:0]                  s1_cidx_ff;
   logic                            s3_valid_ff;
   logic signed [vkis_pkg::PROD_W-1:0] s3_prod_ff;

   // response register
   logic                            rsp_valid_ff;
   logic signed [vkis_pkg::DATA_W-1:0] rsp_conv_ff, rsp_diff_ff;
   logic                            rsp_sat_ff;

   logic accept, iss_valid, iss_capture, load_out, pipe_empty;
   logic tap_last, term_last, scale_done;
   logic [vkis_pkg::HW_W-1:0] sc_total;

   assign accept     = req_valid && req_ready;
   assign pipe_empty = !s1_ff.valid && !s2_ff.valid && !s3_valid_ff;
   assign tap_last   = (kx_ff == k_last) && (ky_ff == k_last);
   assign term_last  = (m_ff == deg_eff);
   assign sc_total   = vkis_pkg::HW_W'(m_ff) + vkis_pkg::HW_W'(l_ff);
   assign scale_done = (sc_ff + 1'b1 == sc_total);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vkis_pkg::ST_IDLE:   if (accept && req_opcode == vkis_pkg::OP_EVALUATE) begin
                                 state_in = vkis_pkg::ST_CENTER;
                              end
         vkis_pkg::ST_CENTER: state_in = vkis_pkg::ST_CWAIT;
         vkis_pkg::ST_CWAIT:  if (pipe_empty) state_in = vkis_pkg::ST_TAPS;
         vkis_pkg::ST_TAPS:   if (tap_last) state_in = vkis_pkg::ST_DRAIN;
         vkis_pkg::ST_DRAIN:  if (pipe_empty) begin
                                 state_in = (sc_total == '0) ? vkis_pkg::ST_ADDT
                                                             : vkis_pkg::ST_SCALE;
                              end
         vkis_pkg::ST_SCALE:  if (scale_done) state_in = vkis_pkg::ST_ADDT;
         vkis_pkg::ST_ADDT:   state_in = term_last ? vkis_pkg::ST_ROUND : vkis_pkg::ST_TAPS;
         vkis_pkg::ST_ROUND:  state_in = vkis_pkg::ST_FINAL;
         vkis_pkg::ST_FINAL:  if (load_out) state_in = vkis_pkg::ST_IDLE;
         default:             state_in = vkis_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = (state_ff == vkis_pkg::ST_IDLE);
      iss_valid   = (state_ff == vkis_pkg::ST_CENTER) || (state_ff == vkis_pkg::ST_TAPS);
      iss_capture = (state_ff == vkis_pkg::ST_CENTER);
      load_out    = (state_ff == vkis_pkg::ST_FINAL) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vkis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memories
   logic                            ref_we, coef_we;
   logic [vkis_pkg::ADDR_W-1:0]     ref_raddr;
   logic [vkis_pkg::DATA_W-1:0]     ref_rdata, coef_rdata;

   assign ref_we  = accept && (req_opcode == vkis_pkg::OP_WRITE_PIXEL);
   assign coef_we = accept && (req_opcode == vkis_pkg::OP_WRITE_COEF)
                    && (32'(req_address) < 32'(COEF_DEPTH));

   vkis_ram #(
      .WIDTH (vkis_pkg::DATA_W),
      .DEPTH (vkis_pkg::REF_DEPTH),
      .AW    (vkis_pkg::ADDR_W)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (req_address),
      .wr_data (req_pixel_value),
      .rd_addr (ref_raddr),
      .rd_data (ref_rdata)
   );

   vkis_ram #(
      .WIDTH (vkis_pkg::DATA_W),
      .DEPTH (COEF_DEPTH),
      .AW    (CIW)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (req_address[CIW-1:0]),
      .wr_data (req_coef_value),
      .rd_addr (s1_cidx_ff),
      .rd_data (coef_rdata)
   );

   // stage 1 -> 2: bounds check and pixel address from the neighbour coordinate
   logic            s1_inr;
   logic [RAW-1:0]  s1_addr;

   always_comb begin
      s1_inr = !s1_nx_ff[vkis_pkg::CRD_W-1] && !s1_ny_ff[vkis_pkg::CRD_W-1]
               && (s1_nx_ff < $signed({1'b0, side_eff}))
               && (s1_ny_ff < $signed({1'b0, side_eff}));
      s1_addr = RAW'(s1_nx_ff[vkis_pkg::CRD_W-3:0])
                + RAW'(s1_ny_ff[vkis_pkg::CRD_W-3:0]) * RAW'(side_eff);
      ref_raddr = s1_addr[vkis_pkg::ADDR_W-1:0];
   end

   // stage 3: select pixel, subtract centre (not at the centre tap), multiply
   logic signed [vkis_pkg::DATA_W:0]   pix;
   logic signed [vkis_pkg::DATA_W:0]   tap_val;
   logic signed [vkis_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      pix     = s2_ff.inr ? (vkis_pkg::DATA_W + 1)'($signed(ref_rdata))
                          : '0;
      tap_val = s2_ff.center ? rc_ff : (pix - rc_ff);
      prod_in = vkis_pkg::PROD_W'($signed(coef_rdata)) * vkis_pkg::PROD_W'(tap_val);
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         s2_ff       <= '0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid   <= iss_valid;
         s1_ff.capture <= iss_capture;
         s1_ff.center  <= (kx_ff == vkis_pkg::KC_W'(hw_eff))
                          && (ky_ff == vkis_pkg::KC_W'(hw_eff));
         s2_ff.valid   <= s1_ff.valid;
         s2_ff.capture <= s1_ff.capture;
         s2_ff.center  <= s1_ff.center;
         s2_ff.inr     <= s1_inr && (s1_addr < RAW'(vkis_pkg::REF_DEPTH));
         s3_valid_ff   <= s2_ff.valid && !s2_ff.capture;
      end
   end

   // datapath registers
   logic [CIW-1:0] tidx_next;
   assign tidx_next = tidx_ff + 1'b1;

   always_ff @(posedge clock) begin
      s1_nx_ff   <= $signed(vkis_pkg::CRD_W'(x_ff)) + $signed(vkis_pkg::CRD_W'(kx_ff))
                    - $signed(vkis_pkg::CRD_W'(hw_eff));
      s1_ny_ff   <= $signed(vkis_pkg::CRD_W'(y_ff)) + $signed(vkis_pkg::CRD_W'(ky_ff))
                    - $signed(vkis_pkg::CRD_W'(hw_eff));
      s1_cidx_ff <= cidx_ff;
      s3_prod_ff <= prod_in;

      if (s2_ff.valid && s2_ff.capture) begin
         rc_ff <= pix;
      end

      case (state_ff)
         vkis_pkg::ST_IDLE: begin
            // latch the word and point the tap counters at the centre
            x_ff        <= req_pos_x;
            y_ff        <= req_pos_y;
            sci_ff      <= req_pixel_value;
            kx_ff       <= vkis_pkg::KC_W'(hw_eff);
            ky_ff       <= vkis_pkg::KC_W'(hw_eff);
            term_acc_ff <= '0;
         end
         vkis_pkg::ST_CWAIT: begin
            kx_ff   <= '0;
            ky_ff   <= '0;
            cidx_ff <= '0;
            tidx_ff <= '0;
            m_ff    <= '0;
            l_ff    <= '0;
            tot_ff  <= '0;
            sc_ff   <= '0;
         end
         vkis_pkg::ST_TAPS: begin
            // advance through the kernel, column fastest
            if (kx_ff == k_last) begin
               kx_ff <= '0;
               ky_ff <= ky_ff + 1'b1;
            end else begin
               kx_ff <= kx_ff + 1'b1;
            end
            cidx_ff <= cidx_ff + CIW'(terms_eff);
         end
         vkis_pkg::ST_SCALE: begin
            // one factor of x or y per cycle
            if (sc_ff < vkis_pkg::HW_W'(m_ff)) begin
               term_acc_ff <= TAW'(term_acc_ff * $signed({1'b0, x_ff}));
            end else begin
               term_acc_ff <= TAW'(term_acc_ff * $signed({1'b0, y_ff}));
            end
            sc_ff <= sc_ff + 1'b1;
         end
         vkis_pkg::ST_ADDT: begin
            tot_ff      <= tot_ff + ACCW'(term_acc_ff);
            term_acc_ff <= '0;
            kx_ff       <= '0;
            ky_ff       <= '0;
            sc_ff       <= '0;
            tidx_ff     <= tidx_next;
            cidx_ff     <= tidx_next;
            if (vkis_pkg::HW_W'(l_ff) + vkis_pkg::HW_W'(m_ff)
                < vkis_pkg::HW_W'(deg_eff)) begin
               l_ff <= l_ff + 1'b1;
            end else begin
               m_ff <= m_ff + 1'b1;
               l_ff <= '0;
            end
         end
         vkis_pkg::ST_ROUND: begin
            // round half up to Q24.8, clamp to +-2^40
            logic signed [ACCW-1:0] biased;
            logic signed [RW-1:0]   shifted;
            biased  = tot_ff + HALF_LSB;
            shifted = RW'(biased >>> 24);
            if (shifted > CLAMP_HI) begin
               rnd_ff <= CLAMP_HI;
            end else if (shifted < CLAMP_LO) begin
               rnd_ff <= CLAMP_LO;
            end else begin
               rnd_ff <= shifted;
            end
         end
         default: ;
      endcase

      // the MAC accumulates while taps drain
      if (s3_valid_ff) begin
         term_acc_ff <= term_acc_ff + TAW'(s3_prod_ff);
      end
   end

   // saturation of both results
   logic signed [RW:0]   diff_full;
   logic signed [vkis_pkg::DATA_W-1:0] conv_sat, diff_sat;
   logic                 conv_clip, diff_clip;
   localparam logic signed [RW:0] S32_HI = (RW + 1)'(64'sd2147483647);
   localparam logic signed [RW:0] S32_LO = (RW + 1)'(-64'sd2147483648);

   always_comb begin
      diff_full = (RW + 1)'(sci_ff) - (RW + 1)'(rnd_ff);
      conv_clip = 1'b0;
      diff_clip = 1'b0;
      if ((RW + 1)'(rnd_ff) > S32_HI) begin
         conv_sat  = 32'sh7FFF_FFFF;
         conv_clip = 1'b1;
      end else if ((RW + 1)'(rnd_ff) < S32_LO) begin
         conv_sat  = 32'sh8000_0000;
         conv_clip = 1'b1;
      end else begin
         conv_sat  = rnd_ff[vkis_pkg::DATA_W-1:0];
      end
      if (diff_full > S32_HI) begin
         diff_sat  = 32'sh7FFF_FFFF;
         diff_clip = 1'b1;
      end else if (diff_full < S32_LO) begin
         diff_sat  = 32'sh8000_0000;
         diff_clip = 1'b1;
      end else begin
         diff_sat  = diff_full[vkis_pkg::DATA_W-1:0];
      end
   end

   // response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_conv_ff <= conv_sat;
         rsp_diff_ff <= diff_sat;
         rsp_sat_ff  <= conv_clip || diff_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_value = rsp_conv_ff;
   assign rsp_difference = rsp_diff_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // checks
   a_ready_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> pipe_empty)
      else $error("word accepted while taps still in flight");

   a_mac_only_in_taps: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (state_ff == vkis_pkg::ST_TAPS || state_ff == vkis_pkg::ST_DRAIN))
      else $error("product arrived outside the tap stream");

   a_cidx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vkis_pkg::ST_TAPS) |-> (32'(cidx_ff) < 32'(COEF_DEPTH)))
      else $error("coefficient index beyond table");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff)
      else $error("response lost on load");

endmodule

`default_nettype wire
